// ----- sv/pcd_pkg.sv -----
// Shared types and constants for the pulse capture detector.
package pcd_pkg;

  // Q1.15 value of one, and the saturation limit of the sample counters.
  localparam logic [15:0] Q15_ONE   = 16'h8000;
  localparam logic [8:0]  CNT_MAX   = 9'd511;
  localparam logic [39:0] ROUND_Q15 = 40'd16384;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN          = 3'd0;
  localparam logic [2:0] REG_SMOOTHING     = 3'd1;
  localparam logic [2:0] REG_POSITIVE_WAIT = 3'd2;
  localparam logic [2:0] REG_END_WAIT      = 3'd3;
  localparam logic [2:0] REG_FALSE_LEVEL   = 3'd4;

  // Sequencer steps around the shared multiplier.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WEIGHT_NEW,
    ST_WEIGHT_OLD,
    ST_FINISH
  } seq_state_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] smoothing_coeff;
    logic [7:0]  positive_wait;
    logic [7:0]  end_wait;
    logic [7:0]  false_level;
  } cfg_t;

  // Step strobes from the sequencer to the detector datapath.
  typedef struct packed {
    logic load_scaled;
    logic load_acc;
    logic finish;
  } ctrl_t;

endpackage

// ----- sv/pcd_if.sv -----
// Request channels of the pulse capture detector: sample input and result output.
interface pcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface pcd_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] filtered;
  logic [23:0] peak_value;
  logic        active;
  logic        start_pulse;
  logic        end_pulse;
  logic        genuine;

  modport source (
    output valid, output filtered, output peak_value, output active,
    output start_pulse, output end_pulse, output genuine, input ready
  );
  modport sink (
    input valid, input filtered, input peak_value, input active,
    input start_pulse, input end_pulse, input genuine, output ready
  );
endinterface

// ----- sv/pcd_mul.sv -----
// Shared 24x16 unsigned multiplier with a registered product.
module pcd_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] a,
  input  logic [15:0] b,
  output logic [39:0] prod
);

  // The product register holds while the sequencer waits.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 40'(a) * 40'(b);
    end
  end

endmodule

// ----- sv/pcd_seq.sv -----
// Sequencer that steps the shared multiplier through scale, new weight and old weight.
module pcd_seq
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pcd_in_if.sink      feed,
  input  cfg_t        cfg,
  input  logic [39:0] prod,
  input  logic [23:0] filter_memory,
  input  logic        out_free,
  output logic        mul_en,
  output logic [23:0] mul_a,
  output logic [15:0] mul_b,
  output ctrl_t       ctrl
);

  seq_state_t  state;
  seq_state_t  state_next;
  logic [15:0] coeff;
  logic [15:0] coeff_rest;

  // Coefficients above one act as one.
  assign coeff      = (cfg.smoothing_coeff > Q15_ONE) ? Q15_ONE : cfg.smoothing_coeff;
  assign coeff_rest = Q15_ONE - coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operands and step strobes.
  always_comb begin
    state_next = state;
    feed.ready = 1'b0;
    mul_en     = 1'b0;
    mul_a      = 24'(feed.sample);
    mul_b      = cfg.gain;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        feed.ready = 1'b1;
        mul_en     = feed.valid;
        if (feed.valid) begin
          state_next = ST_WEIGHT_NEW;
        end
      end
      ST_WEIGHT_NEW: begin
        // The product now holds the scaled sample.
        mul_en           = 1'b1;
        mul_a            = prod[23:0];
        mul_b            = coeff;
        ctrl.load_scaled = 1'b1;
        state_next       = ST_WEIGHT_OLD;
      end
      ST_WEIGHT_OLD: begin
        mul_en        = 1'b1;
        mul_a         = filter_memory;
        mul_b         = coeff_rest;
        ctrl.load_acc = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait here until the result register can take the outcome.
        if (out_free) begin
          ctrl.finish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/pcd_det.sv -----
// Filter, peak hold and capture detection state, with the result register.
module pcd_det
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  ctrl_t       ctrl,
  input  logic [39:0] prod,
  output logic [23:0] filter_memory,
  output logic        out_free,
  pcd_out_if.source   result
);

  logic        capture_on;
  logic [8:0]  positive_run;
  logic [8:0]  held_count;
  logic [23:0] peak_hold;
  logic [23:0] scaled;
  logic [39:0] acc;
  logic        out_valid;

  logic        capture_on_next;
  logic [8:0]  positive_run_next;
  logic [8:0]  held_count_next;
  logic [23:0] filter_memory_next;
  logic [23:0] peak_hold_next;
  logic        start_p;
  logic        end_p;
  logic [40:0] sum;
  logic [23:0] y;
  logic [23:0] level;
  logic [8:0]  run_inc;

  assign out_free     = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign level        = {8'(cfg.false_level), 16'h0} >> 8;

  // Weighted sum, rounded half up, and the detector decisions for one sample.
  always_comb begin
    sum = {1'b0, acc} + {1'b0, prod} + {1'b0, ROUND_Q15};
    y   = sum[38:15];
    held_count_next    = (held_count == CNT_MAX) ? CNT_MAX : held_count + 9'd1;
    run_inc            = (positive_run == CNT_MAX) ? CNT_MAX : positive_run + 9'd1;
    filter_memory_next = y;
    peak_hold_next     = (y > peak_hold) ? y : peak_hold;
    capture_on_next    = capture_on;
    positive_run_next  = positive_run;
    start_p            = 1'b0;
    end_p              = 1'b0;
    if (!capture_on) begin
      if (scaled != 24'd0) begin
        positive_run_next = run_inc;
        if (run_inc > 9'(cfg.positive_wait)) begin
          capture_on_next = 1'b1;
          start_p         = 1'b1;
        end
      end else begin
        // A zero sample while idle restarts everything.
        positive_run_next  = 9'd0;
        held_count_next    = 9'd0;
        filter_memory_next = 24'd0;
        peak_hold_next     = 24'd0;
      end
    end else if (held_count_next > 9'(cfg.end_wait) && scaled <= level) begin
      capture_on_next   = 1'b0;
      positive_run_next = 9'd0;
      end_p             = 1'b1;
    end
  end

  // Intermediate products of the current sample.
  always_ff @(posedge clk) begin
    if (ctrl.load_scaled) begin
      scaled <= prod[23:0];
    end
    if (ctrl.load_acc) begin
      acc <= prod;
    end
  end

  // Detector state.
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_on    <= 1'b0;
      positive_run  <= 9'd0;
      held_count    <= 9'd0;
      filter_memory <= 24'd0;
      peak_hold     <= 24'd0;
    end else if (ctrl.finish) begin
      capture_on    <= capture_on_next;
      positive_run  <= positive_run_next;
      held_count    <= held_count_next;
      filter_memory <= filter_memory_next;
      peak_hold     <= peak_hold_next;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      result.filtered    <= filter_memory_next;
      result.peak_value  <= peak_hold_next;
      result.active      <= capture_on_next;
      result.start_pulse <= start_p;
      result.end_pulse   <= end_p;
      result.genuine     <= (peak_hold_next > level);
    end
  end

endmodule

// ----- sv/pulse_capture_detector_core.sv -----
// Top level of the pulse capture detector: config registers, sequencer, multiplier, detector.
//
//   channel  | role   | payload
//   ---------+--------+----------------------------------------------------------
//   feed     | sink   | sample[7:0]
//   result   | source | filtered, peak_value, active, start_pulse, end_pulse, genuine
//   cfg_*    | write  | cfg_we, cfg_index[2:0], cfg_data[15:0]
//
// Each request passes the accept, new-weight, old-weight and finishing steps in order:
// accept scales the sample, the weight steps form the two filter weights on the one
// shared multiplier, and finishing adds, rounds and updates the detector. The feed is
// ready only in the idle step. A stalled result holds the finishing step until the result
// register frees up. Synchronous reset clears all detector state and loads config defaults.
module pulse_capture_detector_core
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pcd_in_if.sink      feed,
  pcd_out_if.source   result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  ctrl_t       ctrl;
  logic        mul_en;
  logic [23:0] mul_a;
  logic [15:0] mul_b;
  logic [39:0] prod;
  logic [23:0] filter_memory;
  logic        out_free;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain            <= 16'd256;
      cfg.smoothing_coeff <= Q15_ONE;
      cfg.positive_wait   <= 8'd25;
      cfg.end_wait        <= 8'd25;
      cfg.false_level     <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:          cfg.gain            <= cfg_data;
        REG_SMOOTHING:     cfg.smoothing_coeff <= cfg_data;
        REG_POSITIVE_WAIT: cfg.positive_wait   <= cfg_data[7:0];
        REG_END_WAIT:      cfg.end_wait        <= cfg_data[7:0];
        REG_FALSE_LEVEL:   cfg.false_level     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  pcd_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .feed          (feed),
    .cfg           (cfg),
    .prod          (prod),
    .filter_memory (filter_memory),
    .out_free      (out_free),
    .mul_en        (mul_en),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .ctrl          (ctrl)
  );

  pcd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pcd_det u_det (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctrl          (ctrl),
    .prod          (prod),
    .filter_memory (filter_memory),
    .out_free      (out_free),
    .result        (result)
  );

endmodule
